@@ hw/rtl/median_of_group_select_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the median-of-group select unit
// Shared property templates, clocked on a rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_GROUP_SELECT_UNIT_ASSERT_SVH
`define MEDIAN_OF_GROUP_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication: when a holds, c holds in that cycle
`define MGS_ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("mgs: same-cycle check failed");

// Next-cycle implication: when a holds, c holds in the next cycle
`define MGS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("mgs: next-cycle check failed");

`endif

@@ hw/rtl/mgs_pkg.sv @@
// ----------------------------------------------------------------------------
// mgs_pkg
// Sizes and shared types for the median-of-group select unit.
// ----------------------------------------------------------------------------
package mgs_pkg;

	localparam int MAX_GROUP  = 16;
	localparam int DATA_WIDTH = 16;
	localparam int CFG_W      = 5;
	localparam int CNT_W      = $clog2(MAX_GROUP + 1);
	localparam int IDX_W      = $clog2(MAX_GROUP);
	localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(9);

	typedef logic [DATA_WIDTH-1:0] data_t;

	// Data handed from one cell to its right-hand neighbor
	typedef struct packed {
		logic  valid;
		logic  gt;
		data_t value;
	} link_t;

	// Control broadcast from the controller to every cell
	typedef struct packed {
		logic             insert;
		logic             clear;
		logic [IDX_W-1:0] mid_idx;
	} ctrl_t;

endpackage

@@ hw/rtl/mgs_if.sv @@
// ----------------------------------------------------------------------------
// mgs_if
// Valid/ready channels of the median-of-group select unit.
// ----------------------------------------------------------------------------
interface mgs_sample_if;
	import mgs_pkg::*;
	logic  valid;
	logic  ready;
	data_t sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mgs_median_if;
	import mgs_pkg::*;
	logic  valid;
	logic  ready;
	data_t median;
	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

interface mgs_cfg_if;
	import mgs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] group_size;
	modport source (output valid, output group_size, input ready);
	modport sink (input valid, input group_size, output ready);
endinterface

@@ hw/rtl/median_of_group_select_unit.sv @@
// ----------------------------------------------------------------------------
// median_of_group_select_unit
// Keeps each group of samples sorted in a chain of compare cells and gives
// the element at index floor(n/2) once the group is complete.
//
//   channel   modport  payload            accepted when
//   samples   sink     sample[15:0]       valid && ready
//   medians   source   median[15:0]       valid && ready
//   cfg       sink     group_size[4:0]    valid && ready (ready is always high)
//
// One sample is taken every cycle but for the stall below; each cell compares
// it in parallel and shifts or loads in that same cycle.
// The median is registered and appears the cycle after a group's last sample.
// Reset empties the chain and sets the group size to 9.
// Only a group's last sample stalls, while the prior result is still unclaimed.
// ----------------------------------------------------------------------------
module median_of_group_select_unit
	import mgs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mgs_sample_if.sink   samples,
	mgs_median_if.source medians,
	mgs_cfg_if.sink      cfg
);

	ctrl_t ctl;
	link_t links [MAX_GROUP+1];
	data_t value_nxt [MAX_GROUP];
	data_t median_nxt;

	// Chain head: always filled, never greater than the sample
	assign links[0] = '{valid: 1'b1, gt: 1'b0, value: '0};

	// Row of insertion cells
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		mgs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.sample    (samples.sample),
			.ctl       (ctl),
			.left      (links[i]),
			.right     (links[i+1]),
			.value_nxt (value_nxt[i])
		);
	end

	// Pick the middle element of the updated order
	assign median_nxt = value_nxt[ctl.mid_idx];

	mgs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.medians    (medians),
		.cfg        (cfg),
		.median_nxt (median_nxt),
		.ctl        (ctl)
	);

endmodule

@@ hw/rtl/mgs_cell.sv @@
// ----------------------------------------------------------------------------
// mgs_cell
// One slot of the sorted insertion chain: compares, shifts right or loads.
// ----------------------------------------------------------------------------
module mgs_cell
	import mgs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  data_t sample,
	input  ctrl_t ctl,
	input  link_t left,
	output link_t right,
	output data_t value_nxt
);

	data_t value_q;
	logic  valid_q;
	logic  gt;

	// Flag a held value that must move right for the new sample
	assign gt = valid_q && (value_q > sample);
	assign right = '{valid: valid_q, gt: gt, value: value_q};

	// Take the left value on a shift, the sample at the insert point, else keep
	always_comb begin
		if (left.gt) begin
			value_nxt = left.value;
		end else if (gt || !valid_q) begin
			value_nxt = sample;
		end else begin
			value_nxt = value_q;
		end
	end

	// Hold the value; payload needs no reset
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			value_q <= value_nxt;
		end
	end

	// Grow the filled prefix by one per item, drop it when a group completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= valid_q | left.valid;
		end
	end

endmodule

@@ hw/rtl/mgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mgs_ctrl
// Group size register, fill count, handshakes and the result register.
// ----------------------------------------------------------------------------
`include "median_of_group_select_unit_assert.svh"

module mgs_ctrl
	import mgs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mgs_sample_if.sink    samples,
	mgs_median_if.source  medians,
	mgs_cfg_if.sink       cfg,
	input  data_t         median_nxt,
	output ctrl_t         ctl
);

	logic [CFG_W-1:0] group_size_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] eff_size;
	logic [CNT_W-1:0] n_cnt;
	logic             completes;
	logic             accept;
	logic             out_valid_q;
	data_t            median_q;

	// Clamp the group size to 1..MAX_GROUP
	always_comb begin
		if (group_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (int'(group_size_q) > MAX_GROUP) begin
			eff_size = CNT_W'(MAX_GROUP);
		end else begin
			eff_size = CNT_W'(group_size_q);
		end
	end

	// Count including the item on the input, and whether it ends the group
	assign n_cnt     = count_q + CNT_W'(1);
	assign completes = (n_cnt >= eff_size);

	// Stall only a group's last item while the previous result is unclaimed
	assign samples.ready = !out_valid_q || medians.ready || !completes;
	assign accept        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	assign ctl.insert  = accept;
	assign ctl.clear   = accept && completes;
	assign ctl.mid_idx = IDX_W'(n_cnt >> 1);

	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	// Hold the group size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RST;
		end else if (cfg.valid) begin
			group_size_q <= cfg.group_size;
		end
	end

	// Advance the fill count, restart it at the end of a group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= completes ? '0 : n_cnt;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && completes) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the selected element when a group completes
	always_ff @(posedge clk) begin
		if (accept && completes) begin
			median_q <= median_nxt;
		end
	end

	`MGS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, int'(count_q) < MAX_GROUP)
	`MGS_ASSERT_NOW(a_no_overrun, clk, arst_n, out_valid_q && !medians.ready && completes, !samples.ready)
	`MGS_ASSERT_NEXT(a_result_shown, clk, arst_n, accept && completes, out_valid_q)
	`MGS_ASSERT_NEXT(a_count_restart, clk, arst_n, accept && completes, count_q == '0)

endmodule

@@ bench/median_of_group_select_unit_test.sv @@
// ----------------------------------------------------------------------------
// median_of_group_select_unit_test
// Feeds groups of samples into the select unit under several group sizes and
// flow-control patterns, predicts every median from a sorted copy of the
// held values, and checks each median item in order against that prediction.
// ----------------------------------------------------------------------------
module median_of_group_select_unit_test;
	import mgs_pkg::*;

	logic clk;
	logic arst_n;

	mgs_sample_if samples();
	mgs_median_if medians();
	mgs_cfg_if    cfg();

	median_of_group_select_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.medians (medians),
		.cfg     (cfg)
	);

	// Stimulus and flow-control knobs
	data_t       sample_queue[$];
	int unsigned samples_queued;
	int unsigned samples_taken;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Predicted group state
	data_t            held_sorted[MAX_GROUP];
	int unsigned      held_count;
	logic [CFG_W-1:0] group_size_reg;
	data_t            median_expect[$];

	int unsigned fail_count;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Group size as the block applies it: zero acts as one, large values clamp
	function automatic int unsigned effective_group();
		int unsigned s;
		s = group_size_reg;
		if (s == 0) begin
			s = 1;
		end
		if (s > MAX_GROUP) begin
			s = MAX_GROUP;
		end
		return s;
	endfunction

	// Insert one sample in ascending order; predict a median once the group is full
	task automatic insert_sample(input data_t value);
		int unsigned pos;
		pos = held_count;
		if (pos < MAX_GROUP) begin
			while (pos > 0 && held_sorted[pos - 1] > value) begin
				held_sorted[pos] = held_sorted[pos - 1];
				pos--;
			end
			held_sorted[pos] = value;
			held_count++;
		end
		if (held_count >= effective_group()) begin
			median_expect.push_back(held_sorted[(held_count / 2) % MAX_GROUP]);
			held_count = 0;
		end
	endtask

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic queue_sample(input data_t value);
		sample_queue.push_back(value);
		samples_queued++;
	endtask

	// Hold until every queued item is taken and every median has come back
	task automatic wait_drained();
		while (samples_taken != samples_queued || median_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [CFG_W-1:0] size);
		@(posedge clk);
		cfg.valid      <= 1'b1;
		cfg.group_size <= size;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		group_size_reg = size;
	endtask

	// Sample driver: advance to the next queued item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples.valid  <= 1'b0;
			samples.sample <= '0;
		end else begin
			if (samples.valid && samples.ready) begin
				insert_sample(samples.sample);
				samples_taken++;
			end
			if (!samples.valid || samples.ready) begin
				if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					samples.valid  <= 1'b1;
					samples.sample <= sample_queue.pop_front();
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// Median monitor: compare each taken item with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : median_check
		data_t want;
		if (!arst_n) begin
			medians.ready <= 1'b0;
		end else begin
			if (medians.valid && medians.ready) begin
				if (median_expect.size() == 0) begin
					report_fail($sformatf("unexpected median %h", medians.median));
				end else begin
					want = median_expect.pop_front();
					if (medians.median !== want) begin
						report_fail($sformatf("median mismatch: expected %h, got %h",
							want, medians.median));
					end
				end
			end
			medians.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stimulus sequence
	initial begin
		int unsigned      phase;
		int unsigned      k;
		logic [CFG_W-1:0] size;
		data_t            value;

		samples.valid      = 1'b0;
		samples.sample     = '0;
		medians.ready      = 1'b0;
		cfg.valid          = 1'b0;
		cfg.group_size     = '0;
		arst_n             = 1'b0;
		samples_queued     = 0;
		samples_taken      = 0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		held_count         = 0;
		group_size_reg     = GROUP_SIZE_RST;
		fail_count         = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset group size, extremes and a repeated value
		queue_sample(16'hFFFF);
		queue_sample(16'h0000);
		queue_sample(16'h8000);
		queue_sample(16'h7FFF);
		queue_sample(16'h0001);
		queue_sample(16'hFFFE);
		queue_sample(16'h8000);
		queue_sample(16'h5555);
		queue_sample(16'hAAAA);
		wait_drained();

		// Size one: every sample is its own median
		write_group_size(CFG_W'(1));
		queue_sample(16'hFFFF);
		queue_sample(16'h0000);
		wait_drained();

		// Size zero acts as one
		write_group_size(CFG_W'(0));
		queue_sample(16'h1234);
		wait_drained();

		// Oversized group, then shrink it mid-group to an even size
		write_group_size(CFG_W'(31));
		queue_sample(16'h0003);
		queue_sample(16'h0003);
		queue_sample(16'h0001);
		queue_sample(16'h0009);
		queue_sample(16'h0000);
		wait_drained();
		write_group_size(CFG_W'(2));
		queue_sample(16'h0004);
		wait_drained();

		// Random phases over sizes and flow-control patterns
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: size = CFG_W'(16);
				1: size = CFG_W'(1);
				2: size = CFG_W'(31);
				3: size = CFG_W'(2);
				4: size = CFG_W'(0);
				default: size = CFG_W'($urandom_range(3, 15));
			endcase
			write_group_size(size);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 65;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 65;
				end
				default: begin
					send_idle_pct  = 18;
					recv_stall_pct = 18;
				end
			endcase
			// Mix extremes and narrow ranges in to get ties and edge orderings
			for (k = 0; k < 190; k++) begin
				case ($urandom_range(0, 9))
					0: value = '0;
					1: value = '1;
					2, 3: value = data_t'($urandom_range(0, 7));
					default: value = data_t'($urandom);
				endcase
				queue_sample(value);
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
